### sv/iac_pkg.sv
// ----------------------------------------------------------------------------
// iac_pkg: shared types and constants of the complementary attitude filter
// Word formats for the sample and result channels, configuration register
// indexes and reset values, and the CORDIC constants.
// ----------------------------------------------------------------------------
package iac_pkg;

    // Input sample word
    typedef struct packed {
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic        [15:0] elapsed_ms;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] rate_x_smoothed;
        logic signed [15:0] rate_y_smoothed;
        logic signed [15:0] rate_z_smoothed;
        logic               sensor_fault;
    } t_out_word;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACC_WEIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_WEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_OFFSET_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_OFFSET_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_OFFSET_Z   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SMOOTHING = 3'd5;

    localparam logic [15:0]        RST_ACC_WEIGHT     = 16'd1311;
    localparam logic [15:0]        RST_MAG_WEIGHT     = 16'd1311;
    localparam logic signed [11:0] RST_MAG_OFFSET_X   = 12'sd50;
    localparam logic signed [11:0] RST_MAG_OFFSET_Y   = 12'sd20;
    localparam logic signed [11:0] RST_MAG_OFFSET_Z   = 12'sd50;
    localparam logic [15:0]        RST_RATE_SMOOTHING = 16'd32768;

    // CORDIC: angles carry 24 fractional bits
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned CSTEP_W      = 5;
    localparam int unsigned SQRT_STEPS   = 24;

    localparam logic signed [27:0] PI_Z      = 28'sd52707179;
    localparam logic signed [27:0] HALF_PI_Z = 28'sd26353589;
    localparam logic signed [53:0] INV_GAIN  = 54'sd39797;

    localparam logic [27:0] ATAN_TAB [24] = '{
        28'd13176795, 28'd7778716, 28'd4110060, 28'd2086331,
        28'd1047214,  28'd524117,  28'd262123,  28'd131069,
        28'd65536,    28'd32768,   28'd16384,   28'd8192,
        28'd4096,     28'd2048,    28'd1024,    28'd512,
        28'd256,      28'd128,     28'd64,      28'd32,
        28'd16,       28'd8,       28'd4,       28'd2
    };

    // ceil(2^36 / 125): quotient by 125 through a multiply and a shift
    localparam logic [29:0] DIV125_M = 30'd549755814;

endpackage

### sv/imu_complementary_attitude.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude: complementary roll/pitch/yaw filter
// One sensor sample in, one attitude and smoothed-rate word out.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (i_valid/o_ready, i_data) takes one word of accelerometer,
//   gyro and magnetometer triples plus the elapsed milliseconds. Result channel
//   (o_valid/i_ready, o_data) returns one word per sample: roll, pitch, yaw
//   in Q3.13, smoothed rates in Q4.12 and a sensor fault flag.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata while the
//   block is idle; unknown indexes are dropped.
//   Each sample runs through a 24-step square root loop, five passes of 16
//   steps through the shared CORDIC stage, and 39 sequencer steps around the
//   shared multiplier. One sample is in work at a time; a new one is taken
//   only once the sequencer is back in idle. A zero accelerometer or
//   magnetometer vector skips the math, goes straight to the done state and
//   returns the held state. The result sits in an output register; a stalled
//   receiver holds it, and the next sample is already accepted, but its result
//   waits until the register frees up. Reset clears the estimates, the rate
//   filters and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module imu_complementary_attitude (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  iac_pkg::t_in_word                  i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output iac_pkg::t_out_word                 o_data,
    input  logic                               i_cfg_we,
    input  logic [iac_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [iac_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    // Sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SQA  = 5'd1;
    localparam logic [4:0] S_SQB  = 5'd2;
    localparam logic [4:0] S_SQC  = 5'd3;
    localparam logic [4:0] S_SQRT = 5'd4;
    localparam logic [4:0] S_CORD = 5'd5;
    localparam logic [4:0] S_BN   = 5'd6;
    localparam logic [4:0] S_BQ   = 5'd7;
    localparam logic [4:0] S_BI   = 5'd8;
    localparam logic [4:0] S_BA   = 5'd9;
    localparam logic [4:0] S_BB   = 5'd10;
    localparam logic [4:0] S_BC   = 5'd11;
    localparam logic [4:0] S_H1   = 5'd12;
    localparam logic [4:0] S_H2   = 5'd13;
    localparam logic [4:0] S_H3   = 5'd14;
    localparam logic [4:0] S_H4   = 5'd15;
    localparam logic [4:0] S_H5   = 5'd16;
    localparam logic [4:0] S_H6   = 5'd17;
    localparam logic [4:0] S_H7   = 5'd18;
    localparam logic [4:0] S_H8   = 5'd19;
    localparam logic [4:0] S_RA   = 5'd20;
    localparam logic [4:0] S_RB   = 5'd21;
    localparam logic [4:0] S_RC   = 5'd22;
    localparam logic [4:0] S_DONE = 5'd23;

    // CORDIC jobs
    localparam logic [2:0] JOB_ROLL  = 3'd0;
    localparam logic [2:0] JOB_PITCH = 3'd1;
    localparam logic [2:0] JOB_SINP  = 3'd2;
    localparam logic [2:0] JOB_SINT  = 3'd3;
    localparam logic [2:0] JOB_YAW   = 3'd4;

    localparam logic [iac_pkg::CSTEP_W-1:0] CSTEP_LAST =
        iac_pkg::CSTEP_W'(iac_pkg::CORDIC_STEPS - 1);
    localparam logic [iac_pkg::CSTEP_W-1:0] SQSTEP_LAST =
        iac_pkg::CSTEP_W'(iac_pkg::SQRT_STEPS - 1);

    function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
        logic signed [15:0] r;
        if (v > 66'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -66'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Control registers
    logic [4:0]                   r_state;
    logic [2:0]                   r_job;
    logic [1:0]                   r_k;
    logic [iac_pkg::CSTEP_W-1:0]  r_cstep;
    logic                         r_ovalid;
    logic [15:0]                  r_acc_weight;
    logic [15:0]                  r_mag_weight;
    logic signed [11:0]           r_off_x;
    logic signed [11:0]           r_off_y;
    logic signed [11:0]           r_off_z;
    logic [15:0]                  r_smooth;
    logic signed [15:0]           r_est [3];
    logic signed [15:0]           r_rf [3];

    // Datapath registers
    logic signed [15:0]  r_ax, r_ay, r_az;
    logic signed [15:0]  r_g [3];
    logic [15:0]         r_ms;
    logic signed [16:0]  r_mx, r_my, r_mz;
    logic                r_fault;
    logic signed [65:0]  r_prod;
    logic signed [65:0]  r_acc;
    logic [47:0]         r_sq_rem, r_sq_root, r_sq_bit;
    logic signed [53:0]  r_cx, r_cy;
    logic signed [27:0]  r_cz;
    logic                r_cvec, r_czero, r_cflip;
    logic signed [15:0]  r_meas [3];
    logic signed [17:0]  r_sp, r_cp, r_st, r_ct;
    logic signed [24:0]  r_gsum;
    logic signed [53:0]  r_ha;
    iac_pkg::t_out_word  r_out;

    // Combinational signals
    logic signed [16:0]  mag_sx, mag_sy, mag_sz;
    logic                fault_in;
    logic signed [34:0]  mul_a;
    logic signed [30:0]  mul_b;
    logic signed [65:0]  sum_ap;
    logic signed [15:0]  sum_res;
    logic signed [15:0]  g_k;
    logic signed [17:0]  abs_g;
    logic signed [16:0]  ms_s;
    logic [15:0]         w_k;
    logic signed [17:0]  w_s, wn_s, c_s, cn_s;
    logic [31:0]         nq_sum;
    logic signed [30:0]  nq_s;
    logic [22:0]         q_inc;
    logic [47:0]         sq_trial;
    logic signed [53:0]  dx, dy, cx_n, cy_n;
    logic signed [27:0]  tab, cz_n, z_rnd;
    logic                ccw;
    logic signed [15:0]  atan_res;
    logic signed [17:0]  sin_res, cos_res;
    logic signed [53:0]  vec_x, vec_y, ld_vx, ld_vy;
    logic signed [27:0]  ld_vz;
    logic                ld_vzero;
    logic signed [15:0]  rot_ang;
    logic signed [27:0]  rot_z0, ld_rz;
    logic                ld_rflip;
    logic                cord_last;

    // Check the sample for zero vectors
    assign mag_sx   = 17'(i_data.mag_x) + 17'(r_off_x);
    assign mag_sy   = 17'(i_data.mag_y) + 17'(r_off_y);
    assign mag_sz   = 17'(i_data.mag_z) + 17'(r_off_z);
    assign fault_in = (i_data.acc_x == '0 && i_data.acc_y == '0 && i_data.acc_z == '0)
                   || (mag_sx == '0 && mag_sy == '0 && mag_sz == '0);

    // Operand helpers
    assign g_k    = r_g[r_k];
    assign abs_g  = g_k[15] ? -18'(g_k) : 18'(g_k);
    assign ms_s   = {1'b0, r_ms};
    assign w_k    = (r_k == 2'd2) ? r_mag_weight : r_acc_weight;
    assign w_s    = {2'b00, w_k};
    assign wn_s   = 18'sd65536 - w_s;
    assign c_s    = {2'b00, r_smooth};
    assign cn_s   = 18'sd65536 - c_s;
    assign nq_sum = r_prod[31:0] + 32'd250;
    assign nq_s   = {1'b0, nq_sum[31:2]};
    assign q_inc  = r_prod[58:36];

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQA: begin
                mul_a = 35'(r_ax);
                mul_b = 31'(r_ax);
            end
            S_SQB: begin
                mul_a = 35'(r_az);
                mul_b = 31'(r_az);
            end
            S_BN: begin
                mul_a = 35'(abs_g);
                mul_b = 31'(ms_s);
            end
            S_BQ: begin
                mul_a = 35'(nq_s);
                mul_b = 31'(signed'({1'b0, iac_pkg::DIV125_M}));
            end
            S_BA: begin
                mul_a = 35'(r_gsum);
                mul_b = 31'(wn_s);
            end
            S_BB: begin
                mul_a = 35'(r_meas[r_k]);
                mul_b = 31'(w_s);
            end
            S_H1: begin
                mul_a = 35'(r_cp);
                mul_b = 31'(r_my);
            end
            S_H2: begin
                mul_a = 35'(r_sp);
                mul_b = 31'(r_mz);
            end
            S_H3: begin
                mul_a = 35'(r_ct);
                mul_b = 31'(r_mx);
            end
            S_H4: begin
                mul_a = 35'(r_st);
                mul_b = 31'(r_sp);
            end
            S_H5: begin
                mul_a = r_prod[34:0];
                mul_b = 31'(r_my);
            end
            S_H6: begin
                mul_a = 35'(r_st);
                mul_b = 31'(r_cp);
            end
            S_H7: begin
                mul_a = r_prod[34:0];
                mul_b = 31'(r_mz);
            end
            S_RA: begin
                mul_a = 35'(r_rf[r_k]);
                mul_b = 31'(cn_s);
            end
            S_RB: begin
                mul_a = 35'(g_k);
                mul_b = 31'(c_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Accumulate, round half up at bit 16 and saturate
    assign sum_ap  = r_acc + r_prod;
    assign sum_res = sat16((sum_ap + 66'sd32768) >>> 16);

    // Square root trial value
    assign sq_trial = r_sq_root + r_sq_bit;

    // One CORDIC micro-rotation
    assign dx   = r_cy >>> r_cstep;
    assign dy   = r_cx >>> r_cstep;
    assign tab  = signed'(iac_pkg::ATAN_TAB[r_cstep]);
    assign ccw  = r_cvec ? (r_cy > 0) : r_cz[27];
    assign cx_n = ccw ? (r_cx + dx) : (r_cx - dx);
    assign cy_n = ccw ? (r_cy - dy) : (r_cy + dy);
    assign cz_n = ccw ? (r_cz + tab) : (r_cz - tab);

    assign z_rnd    = (cz_n + 28'sd1024) >>> 11;
    assign atan_res = r_czero ? '0 : z_rnd[15:0];
    assign sin_res  = r_cflip ? -cy_n[17:0] : cy_n[17:0];
    assign cos_res  = r_cflip ? -cx_n[17:0] : cx_n[17:0];
    assign cord_last = (r_cstep == CSTEP_LAST);

    // Vectoring inputs and pre-rotation into the right half plane
    always_comb begin
        vec_x = '0;
        vec_y = '0;
        if (r_state == S_SQRT) begin
            vec_y = 54'(r_ax) <<< 8;
            vec_x = 54'(r_az) <<< 8;
        end else if (r_state == S_CORD) begin
            vec_y = 54'(r_ay) <<< 8;
            vec_x = 54'(r_sq_root[23:0]);
        end else if (r_state == S_H8) begin
            vec_y = r_ha;
            vec_x = sum_ap[53:0];
        end
        ld_vzero = (vec_x == '0) && (vec_y == '0);
        if (vec_x < 0) begin
            ld_vx = -vec_x;
            ld_vy = -vec_y;
            ld_vz = (vec_y >= 0) ? iac_pkg::PI_Z : -iac_pkg::PI_Z;
        end else begin
            ld_vx = vec_x;
            ld_vy = vec_y;
            ld_vz = '0;
        end
    end

    // Rotation inputs: fold angles beyond a quarter turn
    assign rot_ang = (r_state == S_CORD) ? r_est[1] : r_est[0];
    assign rot_z0  = 28'(rot_ang) <<< 11;
    always_comb begin
        if (rot_z0 > iac_pkg::HALF_PI_Z) begin
            ld_rz    = rot_z0 - iac_pkg::PI_Z;
            ld_rflip = 1'b1;
        end else if (rot_z0 < -iac_pkg::HALF_PI_Z) begin
            ld_rz    = rot_z0 + iac_pkg::PI_Z;
            ld_rflip = 1'b1;
        end else begin
            ld_rz    = rot_z0;
            ld_rflip = 1'b0;
        end
    end

    // Raise the result flag on a finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && (!r_ovalid || i_ready)) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Sequencer, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_job        <= JOB_ROLL;
            r_k          <= '0;
            r_cstep      <= '0;
            r_acc_weight <= iac_pkg::RST_ACC_WEIGHT;
            r_mag_weight <= iac_pkg::RST_MAG_WEIGHT;
            r_off_x      <= iac_pkg::RST_MAG_OFFSET_X;
            r_off_y      <= iac_pkg::RST_MAG_OFFSET_Y;
            r_off_z      <= iac_pkg::RST_MAG_OFFSET_Z;
            r_smooth     <= iac_pkg::RST_RATE_SMOOTHING;
            for (int i = 0; i < 3; i++) begin
                r_est[i] <= '0;
                r_rf[i]  <= '0;
            end
        end else begin
            // Write a configuration register
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    iac_pkg::CFG_ACC_WEIGHT:     r_acc_weight <= i_cfg_wdata;
                    iac_pkg::CFG_MAG_WEIGHT:     r_mag_weight <= i_cfg_wdata;
                    iac_pkg::CFG_MAG_OFFSET_X:   r_off_x      <= i_cfg_wdata[11:0];
                    iac_pkg::CFG_MAG_OFFSET_Y:   r_off_y      <= i_cfg_wdata[11:0];
                    iac_pkg::CFG_MAG_OFFSET_Z:   r_off_z      <= i_cfg_wdata[11:0];
                    iac_pkg::CFG_RATE_SMOOTHING: r_smooth     <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // Advance the sequencer
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= fault_in ? S_DONE : S_SQA;
                    end
                end
                S_SQA: r_state <= S_SQB;
                S_SQB: r_state <= S_SQC;
                S_SQC: begin
                    r_cstep <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_cstep == SQSTEP_LAST) begin
                        r_cstep <= '0;
                        r_job   <= JOB_ROLL;
                        r_state <= S_CORD;
                    end else begin
                        r_cstep <= r_cstep + 1'b1;
                    end
                end
                S_CORD: begin
                    if (cord_last) begin
                        r_cstep <= '0;
                        unique case (r_job)
                            JOB_ROLL:  r_job <= JOB_PITCH;
                            JOB_PITCH: begin
                                r_k     <= 2'd0;
                                r_state <= S_BN;
                            end
                            JOB_SINP:  r_job <= JOB_SINT;
                            JOB_SINT:  r_state <= S_H1;
                            JOB_YAW: begin
                                r_k     <= 2'd2;
                                r_state <= S_BN;
                            end
                            default:   r_state <= S_IDLE;
                        endcase
                    end else begin
                        r_cstep <= r_cstep + 1'b1;
                    end
                end
                S_BN: r_state <= S_BQ;
                S_BQ: r_state <= S_BI;
                S_BI: r_state <= S_BA;
                S_BA: r_state <= S_BB;
                S_BB: r_state <= S_BC;
                S_BC: begin
                    r_est[r_k] <= sum_res;
                    if (r_k == 2'd0) begin
                        r_k     <= 2'd1;
                        r_state <= S_BN;
                    end else if (r_k == 2'd1) begin
                        r_cstep <= '0;
                        r_job   <= JOB_SINP;
                        r_state <= S_CORD;
                    end else begin
                        r_k     <= 2'd0;
                        r_state <= S_RA;
                    end
                end
                S_H1: r_state <= S_H2;
                S_H2: r_state <= S_H3;
                S_H3: r_state <= S_H4;
                S_H4: r_state <= S_H5;
                S_H5: r_state <= S_H6;
                S_H6: r_state <= S_H7;
                S_H7: r_state <= S_H8;
                S_H8: begin
                    r_cstep <= '0;
                    r_job   <= JOB_YAW;
                    r_state <= S_CORD;
                end
                S_RA: r_state <= S_RB;
                S_RB: r_state <= S_RC;
                S_RC: begin
                    r_rf[r_k] <= sum_res;
                    if (r_k == 2'd2) begin
                        r_k     <= 2'd0;
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RA;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: multiplier, square root, CORDIC and intermediates
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_ax    <= i_data.acc_x;
                    r_ay    <= i_data.acc_y;
                    r_az    <= i_data.acc_z;
                    r_g[0]  <= i_data.gyro_x;
                    r_g[1]  <= i_data.gyro_y;
                    r_g[2]  <= i_data.gyro_z;
                    r_ms    <= i_data.elapsed_ms;
                    r_mx    <= -mag_sx;
                    r_my    <= -mag_sy;
                    r_mz    <= mag_sz;
                    r_fault <= fault_in;
                end
            end
            S_SQB: r_acc <= r_prod;
            S_SQC: begin
                r_sq_rem  <= {sum_ap[31:0], 16'h0000};
                r_sq_root <= '0;
                r_sq_bit  <= 48'h1 << 46;
            end
            S_SQRT: begin
                if (r_sq_rem >= sq_trial) begin
                    r_sq_rem  <= r_sq_rem - sq_trial;
                    r_sq_root <= (r_sq_root >> 1) + r_sq_bit;
                end else begin
                    r_sq_root <= r_sq_root >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                // load roll vectoring after the last root step
                if (r_cstep == SQSTEP_LAST) begin
                    r_cx    <= ld_vx;
                    r_cy    <= ld_vy;
                    r_cz    <= ld_vz;
                    r_cvec  <= 1'b1;
                    r_czero <= ld_vzero;
                    r_cflip <= 1'b0;
                end
            end
            S_CORD: begin
                if (cord_last) begin
                    unique case (r_job)
                        JOB_ROLL: begin
                            r_meas[0] <= atan_res;
                            r_cx      <= ld_vx;
                            r_cy      <= ld_vy;
                            r_cz      <= ld_vz;
                            r_cvec    <= 1'b1;
                            r_czero   <= ld_vzero;
                            r_cflip   <= 1'b0;
                        end
                        JOB_PITCH: r_meas[1] <= atan_res;
                        JOB_SINP: begin
                            r_sp    <= sin_res;
                            r_cp    <= cos_res;
                            r_cx    <= iac_pkg::INV_GAIN;
                            r_cy    <= '0;
                            r_cz    <= ld_rz;
                            r_cvec  <= 1'b0;
                            r_czero <= 1'b0;
                            r_cflip <= ld_rflip;
                        end
                        JOB_SINT: begin
                            r_st <= sin_res;
                            r_ct <= cos_res;
                        end
                        JOB_YAW: r_meas[2] <= atan_res;
                        default: ;
                    endcase
                end else begin
                    r_cx <= cx_n;
                    r_cy <= cy_n;
                    r_cz <= cz_n;
                end
            end
            S_BI: begin
                r_gsum <= 25'(r_est[r_k]) + (g_k[15] ? -25'(signed'({1'b0, q_inc}))
                                                     : 25'(signed'({1'b0, q_inc})));
            end
            S_BB: r_acc <= r_prod;
            S_BC: begin
                // start roll sine and cosine once pitch is blended
                if (r_k == 2'd1) begin
                    r_cx    <= iac_pkg::INV_GAIN;
                    r_cy    <= '0;
                    r_cz    <= ld_rz;
                    r_cvec  <= 1'b0;
                    r_czero <= 1'b0;
                    r_cflip <= ld_rflip;
                end
            end
            S_H2: r_acc <= -r_prod;
            S_H3: r_ha  <= {sum_ap[37:0], 16'h0000};
            S_H4: r_acc <= r_prod <<< 16;
            S_H6: r_acc <= sum_ap;
            S_H8: begin
                r_cx    <= ld_vx;
                r_cy    <= ld_vy;
                r_cz    <= ld_vz;
                r_cvec  <= 1'b1;
                r_czero <= ld_vzero;
                r_cflip <= 1'b0;
            end
            S_RB: r_acc <= r_prod;
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    r_out.roll_angle      <= r_est[0];
                    r_out.pitch_angle     <= r_est[1];
                    r_out.yaw_angle       <= r_est[2];
                    r_out.rate_x_smoothed <= r_rf[0];
                    r_out.rate_y_smoothed <= r_rf[1];
                    r_out.rate_z_smoothed <= r_rf[2];
                    r_out.sensor_fault    <= r_fault;
                end
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // Accepted word goes to the math or straight to the result on a fault
    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_SQA || r_state == S_DONE))
        else $error("accepted word did not start the sequence");

    // CORDIC step counter stays inside the table
    a_cstep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORD) |-> (r_cstep <= CSTEP_LAST))
        else $error("CORDIC step counter out of range");

    // Root loop keeps a single trial bit
    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $onehot(r_sq_bit))
        else $error("square root trial bit lost");

    // A finished word waits while the result register is still full
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !i_ready) |=> (r_state == S_DONE))
        else $error("result overwrote a pending word");

    // Axis index never takes its unused code
    a_axis_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_k != 2'd3))
        else $error("axis index out of range");

endmodule

### tb/imu_complementary_attitude_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_complementary_attitude_test: self-checking bench of the attitude filter
// Drives sensor words through the valid/ready sample channel and predicts each
// result word with an independent fixed-point filter model kept in step with
// the configuration writes. Directed corner samples come first, then random
// flight-like sequences under changing idle patterns and receiver stalls.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_test;

    localparam logic [iac_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [iac_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    iac_pkg::t_in_word              i_data = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    iac_pkg::t_out_word             o_data;
    logic                           i_cfg_we = 1'b0;
    logic [iac_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [iac_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    imu_complementary_attitude dut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state and configuration
    logic [15:0]        w_acc, w_mag, c_rate;
    logic signed [11:0] off_x, off_y, off_z;
    longint             est_roll, est_pitch, est_yaw;
    longint             rate_lp [3];

    iac_pkg::t_out_word attitude_q [$];
    int        fail_count = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        rx_hold_left = 0;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z = 0;
        longint dx, dy;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = (y <= 0) ? longint'(iac_pkg::PI_Z) : -longint'(iac_pkg::PI_Z);
        end
        for (int i = 0; i < iac_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(iac_pkg::ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(iac_pkg::ATAN_TAB[i]);
            end
        end
        return round_shift(z, 11);
    endfunction

    task automatic rotate_unit(input longint ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     flip = 0;
        z = ang * 2048;
        x = longint'(iac_pkg::INV_GAIN);
        y = 0;
        if (z > longint'(iac_pkg::HALF_PI_Z)) begin
            z -= longint'(iac_pkg::PI_Z); flip = 1;
        end else if (z < -longint'(iac_pkg::HALF_PI_Z)) begin
            z += longint'(iac_pkg::PI_Z); flip = 1;
        end
        for (int i = 0; i < iac_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(iac_pkg::ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(iac_pkg::ATAN_TAB[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic longint mix(longint g, longint m, logic [15:0] w);
        return clamp16(round_shift((65536 - longint'(w)) * g + longint'(w) * m, 16));
    endfunction

    function automatic longint gyro_step(longint rate, logic [15:0] ms);
        longint q;
        q = ((rate < 0 ? -rate : rate) * longint'(ms) + 250) / 500;
        return rate < 0 ? -q : q;
    endfunction

    // Advance the filter by one sample and return the expected word
    task automatic predict_attitude(input iac_pkg::t_in_word w,
                                    output iac_pkg::t_out_word r);
        longint ax, ay, az, mx, my, mz, g [3];
        longint roll_m, pitch_m, yaw_m, rad, sp, cp, st, ct, ha, hb;
        bit     fault;
        ax = w.acc_x; ay = w.acc_y; az = w.acc_z;
        g[0] = w.gyro_x; g[1] = w.gyro_y; g[2] = w.gyro_z;
        mx = -(longint'(w.mag_x) + longint'(off_x));
        my = -(longint'(w.mag_y) + longint'(off_y));
        mz = longint'(w.mag_z) + longint'(off_z);
        fault = (ax == 0 && ay == 0 && az == 0) || (mx == 0 && my == 0 && mz == 0);
        if (!fault) begin
            roll_m = vector_angle(ax * 256, az * 256);
            rad = int_sqrt(longint'(ax * ax + az * az) << 16);
            pitch_m = vector_angle(ay * 256, rad);
            est_roll = mix(est_roll + gyro_step(g[0], w.elapsed_ms), roll_m, w_acc);
            est_pitch = mix(est_pitch + gyro_step(g[1], w.elapsed_ms), pitch_m, w_acc);
            rotate_unit(est_roll, sp, cp);
            rotate_unit(est_pitch, st, ct);
            ha = (-cp * my + sp * mz) * 65536;
            hb = ct * mx * 65536 + st * sp * my + st * cp * mz;
            yaw_m = vector_angle(ha, hb);
            est_yaw = mix(est_yaw + gyro_step(g[2], w.elapsed_ms), yaw_m, w_mag);
            for (int k = 0; k < 3; k++)
                rate_lp[k] = clamp16(round_shift((65536 - longint'(c_rate)) * rate_lp[k]
                                                 + longint'(c_rate) * g[k], 16));
        end
        r.roll_angle      = est_roll[15:0];
        r.pitch_angle     = est_pitch[15:0];
        r.yaw_angle       = est_yaw[15:0];
        r.rate_x_smoothed = rate_lp[0][15:0];
        r.rate_y_smoothed = rate_lp[1][15:0];
        r.rate_z_smoothed = rate_lp[2][15:0];
        r.sensor_fault    = fault;
    endtask

    // Receiver: random idling, or a counted hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        iac_pkg::t_out_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (attitude_q.size() == 0) begin
                $display("%0t: unexpected result word, actual %h", $time, o_data);
                fail_count++;
            end else begin
                e = attitude_q.pop_front();
                check_field("roll_angle", e.roll_angle, o_data.roll_angle);
                check_field("pitch_angle", e.pitch_angle, o_data.pitch_angle);
                check_field("yaw_angle", e.yaw_angle, o_data.yaw_angle);
                check_field("rate_x_smoothed", e.rate_x_smoothed, o_data.rate_x_smoothed);
                check_field("rate_y_smoothed", e.rate_y_smoothed, o_data.rate_y_smoothed);
                check_field("rate_z_smoothed", e.rate_z_smoothed, o_data.rate_z_smoothed);
                check_field("sensor_fault", e.sensor_fault, o_data.sensor_fault);
            end
        end
    end

    // Offer one sample word, optionally after an idle gap
    task automatic send_sample(input iac_pkg::t_in_word w);
        iac_pkg::t_out_word r;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        predict_attitude(w, r);
        attitude_q.push_back(r);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        wait (attitude_q.size() == 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [iac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            iac_pkg::CFG_ACC_WEIGHT:     w_acc  = val;
            iac_pkg::CFG_MAG_WEIGHT:     w_mag  = val;
            iac_pkg::CFG_MAG_OFFSET_X:   off_x  = val[11:0];
            iac_pkg::CFG_MAG_OFFSET_Y:   off_y  = val[11:0];
            iac_pkg::CFG_MAG_OFFSET_Z:   off_z  = val[11:0];
            iac_pkg::CFG_RATE_SMOOTHING: c_rate = val;
            default: ;
        endcase
    endtask

    task automatic set_filter(input logic [15:0] wa, input logic [15:0] wm,
                              input logic [15:0] ox, input logic [15:0] oy,
                              input logic [15:0] oz, input logic [15:0] cr);
        write_reg(iac_pkg::CFG_ACC_WEIGHT, wa);
        write_reg(iac_pkg::CFG_MAG_WEIGHT, wm);
        write_reg(iac_pkg::CFG_MAG_OFFSET_X, ox);
        write_reg(iac_pkg::CFG_MAG_OFFSET_Y, oy);
        write_reg(iac_pkg::CFG_MAG_OFFSET_Z, oz);
        write_reg(iac_pkg::CFG_RATE_SMOOTHING, cr);
    endtask

    function automatic iac_pkg::t_in_word make_sample(
            logic signed [15:0] ax, logic signed [15:0] ay,
            logic signed [15:0] az, logic signed [15:0] gx,
            logic signed [15:0] gy, logic signed [15:0] gz,
            logic signed [15:0] mx, logic signed [15:0] my,
            logic signed [15:0] mz, logic [15:0] ms);
        iac_pkg::t_in_word w;
        w = '{ax, ay, az, gx, gy, gz, mx, my, mz, ms};
        return w;
    endfunction

    // Random sample: mostly plausible flight data, some raw noise and faults
    function automatic iac_pkg::t_in_word random_sample();
        iac_pkg::t_in_word w;
        int       kind;
        w = iac_pkg::t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
        kind = $urandom_range(99);
        if (kind < 70) begin
            w.acc_x = 16'($urandom_range(8000) - 4000);
            w.acc_y = 16'($urandom_range(8000) - 4000);
            w.acc_z = 16'($urandom_range(16000) - 4000);
            w.gyro_x = 16'($urandom_range(16000) - 8000);
            w.gyro_y = 16'($urandom_range(16000) - 8000);
            w.gyro_z = 16'($urandom_range(16000) - 8000);
            w.mag_x = 16'($urandom_range(1200) - 600);
            w.mag_y = 16'($urandom_range(1200) - 600);
            w.mag_z = 16'($urandom_range(1200) - 600);
            w.elapsed_ms = 16'($urandom_range(1, 20));
        end else if (kind < 76) begin
            w.acc_x = '0; w.acc_y = '0; w.acc_z = '0;
        end else if (kind < 82) begin
            w.mag_x = -16'(off_x); w.mag_y = -16'(off_y); w.mag_z = -16'(off_z);
        end else if (kind < 86) begin
            w.acc_x = '0;
            if ($urandom_range(1)) w.acc_z = '0;
        end
        return w;
    endfunction

    task automatic test_directed_corners();
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0,
                                16'sd200, 16'sd100, -16'sd300, 16'd10));
        send_sample(make_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                                16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'd65535));
        send_sample(make_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                16'sh8000, 16'd65535));
        // accel x and z both zero, y carries the tilt
        send_sample(make_sample(16'sd0, 16'sd5000, 16'sd0, 16'sd100, -16'sd100, 16'sd0,
                                16'sd10, 16'sd10, 16'sd10, 16'd0));
        // zero y against negative x lands on plus pi
        send_sample(make_sample(16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd0,
                                -16'sd50, -16'sd20, -16'sd400, 16'd5));
        // zero accelerometer, then magnetometer cancelled by its offsets
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd0, 16'sd1000, 16'sd1000, 16'sd1000,
                                16'sd100, 16'sd100, 16'sd100, 16'd10));
        send_sample(make_sample(16'sd100, 16'sd100, 16'sd100, 16'sd1000, 16'sd1000,
                                16'sd1000, -16'sd50, -16'sd20, -16'sd50, 16'd10));
        // large rotations wind the estimates past pi/2 and into saturation
        for (int i = 0; i < 6; i++)
            send_sample(make_sample(-16'sd3000, 16'sd2000, -16'sd500, 16'sd30000,
                                    -16'sd30000, 16'sd30000, 16'sd300, -16'sd200,
                                    16'sd100, 16'd2000));
        drain_results();
    endtask

    task automatic test_config_extremes();
        set_filter(16'd0, 16'd0, 16'hF800, 16'h07FF, 16'hF800, 16'd0);
        repeat (8) send_sample(random_sample());
        drain_results();
        set_filter(16'd65535, 16'd65535, 16'h07FF, 16'hF800, 16'h07FF, 16'd65535);
        repeat (8) send_sample(random_sample());
        drain_results();
        // spare indexes must leave every register alone
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h1234);
        repeat (4) send_sample(random_sample());
        drain_results();
    endtask

    task automatic test_random_flight(input int n, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        set_filter(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
        for (int i = 0; i < n; i++) begin
            // occasionally pause until the pipe is empty and retune the filter
            if (i % 150 == 149) begin
                drain_results();
                write_reg(iac_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_B)), 16'($urandom));
            end
            send_sample(random_sample());
        end
        drain_results();
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_left = 3000;
        repeat (6) send_sample(random_sample());
        drain_results();
        repeat (4) send_sample(random_sample());
        drain_results();
    endtask

    // Abort a hung run
    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        w_acc = iac_pkg::RST_ACC_WEIGHT;
        w_mag = iac_pkg::RST_MAG_WEIGHT;
        off_x = iac_pkg::RST_MAG_OFFSET_X;
        off_y = iac_pkg::RST_MAG_OFFSET_Y;
        off_z = iac_pkg::RST_MAG_OFFSET_Z;
        c_rate = iac_pkg::RST_RATE_SMOOTHING;
        est_roll = 0; est_pitch = 0; est_yaw = 0;
        rate_lp = '{0, 0, 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_config_extremes();
        test_random_flight(440, 33, 70);
        test_output_stall();
        test_random_flight(440, 70, 33);
        test_random_flight(440, 0, 0);

        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
